/* sv/sss_pkg.sv */
`default_nettype none

package sss_pkg;

    localparam int unsigned DIGIT_COUNT = 4;

    localparam logic [1:0] REQ_NONE    = 2'd0;
    localparam logic [1:0] REQ_DECIMAL = 2'd1;
    localparam logic [1:0] REQ_RAW     = 2'd2;
    localparam logic [1:0] REQ_BRIGHT  = 2'd3;

    localparam logic [7:0] CMD_DATA   = 8'h40;
    localparam logic [7:0] CMD_ADDR   = 8'hc0;
    localparam logic [7:0] CMD_BRIGHT = 8'h87;

    localparam logic [15:0] TICKS_RESET = 16'd20;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START_A,
        PH_START_B,
        PH_BIT_LO,
        PH_BIT_HI,
        PH_ACK_LO,
        PH_ACK_HI,
        PH_STOP_A,
        PH_STOP_B,
        PH_STOP_C
    } t_phase;

    typedef enum logic [1:0] {
        UNITS_2,
        UNITS_3,
        UNITS_5
    } t_units;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [13:0] value;
        logic [2:0]  separator_pos;
        logic [7:0]  seg_first;
        logic [7:0]  seg_second;
        logic [7:0]  seg_third;
        logic [7:0]  seg_fourth;
        logic [3:0]  brightness;
    } t_in_item;

    typedef struct packed {
        logic clk_out;
        logic dio_out;
        logic busy_res;
        logic req_ignored;
    } t_out_item;

    typedef struct packed {
        logic [10:0] div10;
        logic [7:0]  div100;
        logic [4:0]  div1000;
    } t_quot;

    typedef logic [DIGIT_COUNT-1:0][7:0] t_frame;

    function automatic logic [7:0] seg_of(input logic [3:0] digit);
        logic [7:0] seg;
        unique case (digit)
            4'd0:    seg = 8'h3f;
            4'd1:    seg = 8'h06;
            4'd2:    seg = 8'h5b;
            4'd3:    seg = 8'h4f;
            4'd4:    seg = 8'h66;
            4'd5:    seg = 8'h6d;
            4'd6:    seg = 8'h7d;
            4'd7:    seg = 8'h07;
            4'd8:    seg = 8'h7f;
            4'd9:    seg = 8'h6f;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

    function automatic logic [18:0] delay_ticks(input logic [15:0] ticks, input t_units units);
        logic [18:0] t;
        unique case (units)
            UNITS_2: t = {2'b00, ticks, 1'b0};
            UNITS_3: t = {2'b00, ticks, 1'b0} + {3'b000, ticks};
            default: t = {1'b0, ticks, 2'b00} + {3'b000, ticks};
        endcase
        if (t == 19'd0) begin
            t = 19'd1;
        end
        return t;
    endfunction

endpackage

`default_nettype wire

/* sv/sss_bcd.sv */
`default_nettype none

module sss_bcd (
    input  wire logic [13:0]   i_value,
    output sss_pkg::t_quot     o_quot
);
    import sss_pkg::*;

    localparam logic [29:0] RECIP_10   = 30'd52429;
    localparam logic [29:0] RECIP_100  = 30'd41944;
    localparam logic [29:0] RECIP_1000 = 30'd16778;

    logic [29:0] w_p10;
    logic [29:0] w_p100;
    logic [29:0] w_p1000;

    assign w_p10   = {16'd0, i_value} * RECIP_10;
    assign w_p100  = {16'd0, i_value} * RECIP_100;
    assign w_p1000 = {16'd0, i_value} * RECIP_1000;

    assign o_quot.div10   = w_p10[29:19];
    assign o_quot.div100  = w_p100[29:22];
    assign o_quot.div1000 = w_p1000[28:24];

endmodule

`default_nettype wire

/* sv/sss_seq.sv */
`default_nettype none

module sss_seq (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_step,
    input  sss_pkg::t_in_item  i_item,
    input  sss_pkg::t_quot     i_quot,
    input  wire logic [15:0]   i_ticks,
    output sss_pkg::t_out_item o_result
);
    import sss_pkg::*;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_bit_idx, n_bit_idx;
    logic [2:0]  r_byte_idx, n_byte_idx;
    logic [18:0] r_delay, n_delay;
    logic [7:0]  r_shift, n_shift;
    t_frame      r_frame, n_frame;
    logic [7:0]  r_bcmd, n_bcmd;
    logic [1:0]  r_kind, n_kind;
    logic        r_clk, n_clk;
    logic        r_dio, n_dio;
    logic        w_ignored;
    logic        w_busy;
    logic [3:0]  w_digit [DIGIT_COUNT];

    function automatic logic [7:0] pick_byte(input logic [1:0] kind, input logic [2:0] idx,
                                             input t_frame frame, input logic [7:0] bcmd);
        logic [7:0] b;
        if (kind == REQ_BRIGHT) begin
            b = bcmd;
        end else if (idx == 3'd0) begin
            b = CMD_DATA;
        end else if (idx == 3'd1) begin
            b = CMD_ADDR;
        end else if (idx <= 3'd5) begin
            b = frame[2'(idx - 3'd2)];
        end else begin
            b = 8'h00;
        end
        return b;
    endfunction

    assign w_digit[0] = i_item.value[3:0] - {i_quot.div10[0], 3'b000}
                        - {i_quot.div10[2:0], 1'b0};
    assign w_digit[1] = i_quot.div10[3:0] - {i_quot.div100[0], 3'b000}
                        - {i_quot.div100[2:0], 1'b0};
    assign w_digit[2] = i_quot.div100[3:0] - {i_quot.div1000[0], 3'b000}
                        - {i_quot.div1000[2:0], 1'b0};
    assign w_digit[3] = (i_quot.div1000 >= 5'd10) ? 4'(i_quot.div1000 - 5'd10)
                                                  : i_quot.div1000[3:0];

    always_comb begin
        n_phase    = r_phase;
        n_bit_idx  = r_bit_idx;
        n_byte_idx = r_byte_idx;
        n_delay    = r_delay;
        n_shift    = r_shift;
        n_frame    = r_frame;
        n_bcmd     = r_bcmd;
        n_kind     = r_kind;
        n_clk      = r_clk;
        n_dio      = r_dio;
        w_ignored  = 1'b0;

        if (i_item.req_type != REQ_NONE) begin
            if (r_phase != PH_IDLE) begin
                w_ignored = 1'b1;
            end else begin
                n_kind     = i_item.req_type;
                n_byte_idx = 3'd0;
                priority if (i_item.req_type == REQ_DECIMAL) begin
                    for (int i = 0; i < DIGIT_COUNT; i++) begin
                        n_frame[DIGIT_COUNT-1-i] = seg_of(w_digit[i])
                            | {(i_item.separator_pos == 3'(i)), 7'b0000000};
                    end
                end else if (i_item.req_type == REQ_RAW) begin
                    n_frame[0] = i_item.seg_first;
                    n_frame[1] = i_item.seg_second;
                    n_frame[2] = i_item.seg_third;
                    n_frame[3] = i_item.seg_fourth;
                end else begin
                    n_bcmd = CMD_BRIGHT + {4'b0000, i_item.brightness};
                end
                n_clk   = 1'b1;
                n_dio   = 1'b1;
                n_phase = PH_START_A;
                n_delay = delay_ticks(i_ticks, UNITS_2);
            end
        end

        w_busy = (n_phase != PH_IDLE);
        o_result.clk_out     = n_clk;
        o_result.dio_out     = n_dio;
        o_result.busy_res    = w_busy;
        o_result.req_ignored = w_ignored;

        if (w_busy) begin
            if (n_delay != 19'd0) begin
                n_delay = n_delay - 19'd1;
            end
            if (n_delay == 19'd0) begin
                unique case (n_phase)
                    PH_START_A: begin
                        n_dio   = 1'b0;
                        n_phase = PH_START_B;
                        n_delay = 19'd1;
                    end
                    PH_START_B: begin
                        n_shift   = pick_byte(n_kind, n_byte_idx, n_frame, n_bcmd);
                        n_bit_idx = 3'd0;
                        n_clk     = 1'b0;
                        n_dio     = n_shift[0];
                        n_phase   = PH_BIT_LO;
                        n_delay   = delay_ticks(i_ticks, UNITS_3);
                    end
                    PH_BIT_LO: begin
                        n_clk   = 1'b1;
                        n_phase = PH_BIT_HI;
                        n_delay = delay_ticks(i_ticks, UNITS_3);
                    end
                    PH_BIT_HI: begin
                        n_shift = {1'b0, n_shift[7:1]};
                        n_clk   = 1'b0;
                        if (n_bit_idx == 3'd7) begin
                            n_phase = PH_ACK_LO;
                            n_delay = delay_ticks(i_ticks, UNITS_5);
                        end else begin
                            n_bit_idx = n_bit_idx + 3'd1;
                            n_dio     = n_shift[0];
                            n_phase   = PH_BIT_LO;
                            n_delay   = delay_ticks(i_ticks, UNITS_3);
                        end
                    end
                    PH_ACK_LO: begin
                        n_clk   = 1'b1;
                        n_phase = PH_ACK_HI;
                        n_delay = delay_ticks(i_ticks, UNITS_2);
                    end
                    PH_ACK_HI: begin
                        if (n_kind == REQ_BRIGHT || n_byte_idx == 3'd0
                                || n_byte_idx >= 3'd5) begin
                            n_clk   = 1'b0;
                            n_phase = PH_STOP_A;
                            n_delay = delay_ticks(i_ticks, UNITS_2);
                        end else begin
                            n_byte_idx = n_byte_idx + 3'd1;
                            n_shift    = pick_byte(n_kind, n_byte_idx, n_frame, n_bcmd);
                            n_bit_idx  = 3'd0;
                            n_clk      = 1'b0;
                            n_dio      = n_shift[0];
                            n_phase    = PH_BIT_LO;
                            n_delay    = delay_ticks(i_ticks, UNITS_3);
                        end
                    end
                    PH_STOP_A: begin
                        n_dio   = 1'b0;
                        n_phase = PH_STOP_B;
                        n_delay = delay_ticks(i_ticks, UNITS_2);
                    end
                    PH_STOP_B: begin
                        n_clk   = 1'b1;
                        n_phase = PH_STOP_C;
                        n_delay = delay_ticks(i_ticks, UNITS_2);
                    end
                    PH_STOP_C: begin
                        n_clk = 1'b1;
                        n_dio = 1'b1;
                        if (n_kind != REQ_BRIGHT && n_byte_idx == 3'd0) begin
                            n_byte_idx = 3'd1;
                            n_phase    = PH_START_A;
                            n_delay    = delay_ticks(i_ticks, UNITS_2);
                        end else begin
                            n_phase = PH_IDLE;
                            n_delay = 19'd0;
                            n_kind  = REQ_NONE;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                        n_delay = 19'd0;
                        n_clk   = 1'b1;
                        n_dio   = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_bit_idx  <= 3'd0;
            r_byte_idx <= 3'd0;
            r_delay    <= 19'd0;
            r_shift    <= 8'h00;
            r_kind     <= REQ_NONE;
            r_clk      <= 1'b1;
            r_dio      <= 1'b1;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_bit_idx  <= n_bit_idx;
            r_byte_idx <= n_byte_idx;
            r_delay    <= n_delay;
            r_shift    <= n_shift;
            r_kind     <= n_kind;
            r_clk      <= n_clk;
            r_dio      <= n_dio;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_frame <= n_frame;
            r_bcmd  <= n_bcmd;
        end
    end

    a_idle_bus_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_clk && r_dio))
        else $error("Bus is not released high while the sequencer is idle.");

    a_idle_no_delay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_delay == 19'd0))
        else $error("Delay counter is running while the sequencer is idle.");

    a_low_clock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BIT_LO || r_phase == PH_ACK_LO) |-> !r_clk)
        else $error("Clock line is high during a low clock phase.");

    a_busy_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_phase != PH_IDLE && i_item.req_type != REQ_NONE)
            |-> (o_result.req_ignored && o_result.busy_res))
        else $error("Request during a transfer was not flagged as dropped.");

    a_hold_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_phase) && $stable(r_delay))
        else $error("Sequencer state moved without a tick.");

endmodule

`default_nettype wire

/* sv/seven_segment_two_wire_sender.sv */
// Two-wire seven-segment display sender. Every transfer on the input channel is one clock
// tick of the pin sequencer and yields exactly one result carrying the clock and data pin
// levels for that tick, a busy flag and a flag for a request dropped because a frame was
// still going out. The block takes one tick per clock cycle unless the output stalls; a
// tick passes the input register and then the result register, and input ready only
// drops while a finished result waits at the output. A decimal or raw request sends a
// 0x40 command frame and then a 0xc0 address frame with four segment bytes; a brightness
// request sends one frame with 0x87 plus the level. Bit timing uses ticks_per_delay_unit
// ticks per unit; the user must write the configuration port only while idle, unchecked.
`default_nettype none

module seven_segment_two_wire_sender (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  sss_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output sss_pkg::t_out_item o_out,
    input  wire logic          i_cfg_we,
    input  wire logic [15:0]   i_cfg_data
);
    import sss_pkg::*;

    logic        r_in_valid;
    t_in_item    r_in;
    t_quot       r_quot;
    logic        r_out_valid;
    t_out_item   r_out;
    logic [15:0] r_ticks;
    t_quot       w_quot;
    t_out_item   w_result;
    logic        w_advance;
    logic        w_step;
    logic        w_in_fire;

    assign w_advance   = !r_out_valid || i_out_ready;
    assign w_step      = r_in_valid && w_advance;
    assign o_in_ready  = !r_in_valid || w_advance;
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    sss_bcd u_bcd (
        .i_value (i_in.value),
        .o_quot  (w_quot)
    );

    sss_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_item   (r_in),
        .i_quot   (r_quot),
        .i_ticks  (r_ticks),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_ticks     <= TICKS_RESET;
        end else begin
            if (w_in_fire) begin
                r_in_valid <= 1'b1;
            end else if (w_step) begin
                r_in_valid <= 1'b0;
            end
            if (w_step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_ticks <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_in   <= i_in;
            r_quot <= w_quot;
        end
        if (w_step) begin
            r_out <= w_result;
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid)
        else $error("Pending result was lost before its transfer.");

    a_step_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> r_out_valid)
        else $error("Processed tick did not reach the result register.");

    a_input_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_in)))
        else $error("Stalled tick in the input register changed.");

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sss_pkg::*;

    localparam int unsigned RUN_LIMIT    = 2_000_000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned RANDOM_TICKS = 140;
    localparam int unsigned PHASES       = 5;
    localparam logic [7:0] DIGIT_GLYPH [10] = '{
        8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
    };

    typedef struct {
        logic        set_cfg;
        logic [15:0] cfg;
        t_in_item    item;
        logic        typed;
        t_out_item   pins;
        logic        drain;
    } t_row;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    t_in_item    in_item   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_item   out_item;
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_data  = '0;

    // Shadow of the pin sequencer, advanced once per accepted tick.
    logic [15:0] unit_ticks  = TICKS_RESET;
    t_phase      seq_ph      = PH_IDLE;
    logic [2:0]  bit_no      = '0;
    logic [2:0]  byte_no     = '0;
    logic [18:0] wait_left   = '0;
    logic [7:0]  shift_reg   = '0;
    logic [7:0]  seg_bytes [DIGIT_COUNT];
    logic [7:0]  bright_byte = '0;
    logic [1:0]  req_kind    = REQ_NONE;
    logic        clk_lvl     = 1'b1;
    logic        dio_lvl     = 1'b1;

    t_out_item   pending_pins [$];
    t_row        directed_rows [$];

    int unsigned cycle_count = 0;
    int unsigned n_ticks     = 0;
    int unsigned n_checked   = 0;
    int unsigned n_started   = 0;
    int unsigned n_dropped   = 0;
    int unsigned n_cfg       = 0;
    int unsigned n_bad       = 0;
    int unsigned n_stray     = 0;
    bit          gaps_on      = 1'b1;
    bit          stalls_on    = 1'b1;
    bit          hold_request = 1'b0;

    seven_segment_two_wire_sender dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    task automatic enter_phase(input t_phase ph, input int unsigned units);
        int unsigned t;
        t = units * unit_ticks;
        seq_ph = ph;
        wait_left = (t == 0) ? 19'd1 : t[18:0];
    endtask

    function automatic logic [7:0] byte_on_wire();
        if (req_kind == REQ_BRIGHT) begin
            return bright_byte;
        end
        if (byte_no == 3'd0) begin
            return CMD_DATA;
        end
        if (byte_no == 3'd1) begin
            return CMD_ADDR;
        end
        if (byte_no <= DIGIT_COUNT + 1) begin
            return seg_bytes[byte_no - 2];
        end
        return 8'h00;
    endfunction

    task automatic load_byte();
        shift_reg = byte_on_wire();
        bit_no = '0;
        clk_lvl = 1'b0;
        dio_lvl = shift_reg[0];
        enter_phase(PH_BIT_LO, 3);
    endtask

    task automatic advance_sequencer();
        case (seq_ph)
            PH_START_A: begin
                dio_lvl = 1'b0;
                seq_ph = PH_START_B;
                wait_left = 19'd1;
            end
            PH_START_B: begin
                load_byte();
            end
            PH_BIT_LO: begin
                clk_lvl = 1'b1;
                enter_phase(PH_BIT_HI, 3);
            end
            PH_BIT_HI: begin
                shift_reg = shift_reg >> 1;
                clk_lvl = 1'b0;
                if (bit_no == 3'd7) begin
                    enter_phase(PH_ACK_LO, 5);
                end else begin
                    bit_no = bit_no + 3'd1;
                    dio_lvl = shift_reg[0];
                    enter_phase(PH_BIT_LO, 3);
                end
            end
            PH_ACK_LO: begin
                clk_lvl = 1'b1;
                enter_phase(PH_ACK_HI, 2);
            end
            PH_ACK_HI: begin
                if (req_kind == REQ_BRIGHT || byte_no == 3'd0 || byte_no >= DIGIT_COUNT + 1) begin
                    clk_lvl = 1'b0;
                    enter_phase(PH_STOP_A, 2);
                end else begin
                    byte_no = byte_no + 3'd1;
                    load_byte();
                end
            end
            PH_STOP_A: begin
                dio_lvl = 1'b0;
                enter_phase(PH_STOP_B, 2);
            end
            PH_STOP_B: begin
                clk_lvl = 1'b1;
                enter_phase(PH_STOP_C, 2);
            end
            PH_STOP_C: begin
                clk_lvl = 1'b1;
                dio_lvl = 1'b1;
                if (req_kind != REQ_BRIGHT && byte_no == 3'd0) begin
                    byte_no = 3'd1;
                    enter_phase(PH_START_A, 2);
                end else begin
                    seq_ph = PH_IDLE;
                    wait_left = '0;
                    req_kind = REQ_NONE;
                end
            end
            default: begin
                seq_ph = PH_IDLE;
                wait_left = '0;
                clk_lvl = 1'b1;
                dio_lvl = 1'b1;
            end
        endcase
    endtask

    task automatic predict_pins(input t_in_item it, output t_out_item pins);
        logic        dropped;
        logic        busy;
        int unsigned v;
        int unsigned i;
        logic [7:0]  glyph;
        dropped = 1'b0;
        if (it.req_type != REQ_NONE) begin
            if (seq_ph != PH_IDLE) begin
                dropped = 1'b1;
                n_dropped++;
            end else begin
                n_started++;
                req_kind = it.req_type;
                byte_no = '0;
                if (it.req_type == REQ_DECIMAL) begin
                    v = it.value;
                    for (i = 0; i < DIGIT_COUNT; i++) begin
                        glyph = DIGIT_GLYPH[v % 10];
                        if (i == it.separator_pos) begin
                            glyph[7] = 1'b1;
                        end
                        seg_bytes[DIGIT_COUNT - 1 - i] = glyph;
                        v = v / 10;
                    end
                end else if (it.req_type == REQ_RAW) begin
                    seg_bytes[0] = it.seg_first;
                    seg_bytes[1] = it.seg_second;
                    seg_bytes[2] = it.seg_third;
                    seg_bytes[3] = it.seg_fourth;
                end else begin
                    bright_byte = CMD_BRIGHT + {4'b0000, it.brightness};
                end
                clk_lvl = 1'b1;
                dio_lvl = 1'b1;
                enter_phase(PH_START_A, 2);
            end
        end
        busy = (seq_ph != PH_IDLE);
        pins.clk_out = clk_lvl;
        pins.dio_out = dio_lvl;
        pins.busy_res = busy;
        pins.req_ignored = dropped;
        if (busy) begin
            if (wait_left > 0) begin
                wait_left = wait_left - 19'd1;
            end
            if (wait_left == 0) begin
                advance_sequencer();
            end
        end
    endtask

    function automatic t_in_item random_tick(input logic may_request);
        t_in_item    it;
        int unsigned pick;
        it.req_type = REQ_NONE;
        it.value = ($urandom_range(0, 3) == 0) ? 14'($urandom_range(0, 16383))
                                               : 14'($urandom_range(0, 9999));
        it.separator_pos = 3'($urandom_range(0, 7));
        it.seg_first = 8'($urandom);
        it.seg_second = 8'($urandom);
        it.seg_third = 8'($urandom);
        it.seg_fourth = 8'($urandom);
        it.brightness = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                    : 4'($urandom_range(0, 8));
        pick = $urandom_range(0, 99);
        if (may_request && (seq_ph == PH_IDLE ? pick < 60 : pick < 4)) begin
            case ($urandom_range(0, 2))
                0: it.req_type = REQ_DECIMAL;
                1: it.req_type = REQ_RAW;
                default: it.req_type = REQ_BRIGHT;
            endcase
        end
        return it;
    endfunction

    task automatic send_tick(input t_in_item it, input logic typed, input t_out_item pins);
        int unsigned gap;
        t_out_item   predicted;
        gap = gaps_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_pins(it, predicted);
        pending_pins.push_back(typed ? pins : predicted);
        n_ticks++;
    endtask

    task automatic drain_sequencer();
        bit g;
        bit s;
        g = gaps_on;
        s = stalls_on;
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        while (seq_ph != PH_IDLE) send_tick(random_tick(1'b0), 1'b0, '0);
        gaps_on = g;
        stalls_on = s;
    endtask

    task automatic write_delay_unit(input logic [15:0] ticks);
        in_valid <= 1'b0;
        while (pending_pins.size() != 0) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= ticks;
        @(posedge clk);
        unit_ticks = ticks;
        cfg_we <= 1'b0;
        n_cfg++;
    endtask

    task automatic add_row(input logic set_cfg, input logic [15:0] cfg, input logic [1:0] req,
                           input logic [13:0] value, input logic [2:0] sep,
                           input logic [31:0] segs, input logic [3:0] level,
                           input logic typed, input logic [3:0] pins, input logic drain);
        t_row r;
        r.set_cfg = set_cfg;
        r.cfg = cfg;
        r.item.req_type = req;
        r.item.value = value;
        r.item.separator_pos = sep;
        r.item.seg_first = segs[31:24];
        r.item.seg_second = segs[23:16];
        r.item.seg_third = segs[15:8];
        r.item.seg_fourth = segs[7:0];
        r.item.brightness = level;
        r.typed = typed;
        r.pins = t_out_item'(pins);
        r.drain = drain;
        directed_rows.push_back(r);
    endtask

    initial begin
        t_out_item   want;
        int unsigned stall;
        wait (rst_n === 1'b1);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                stall = stalls_on ? $urandom_range(0, 7) : 0;
                if (stall > 0) begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            if (pending_pins.size() == 0) begin
                n_stray++;
                if (n_bad + n_stray <= 10) begin
                    $display("unexpected pin result: clk %b dio %b busy %b dropped %b",
                             out_item.clk_out, out_item.dio_out, out_item.busy_res,
                             out_item.req_ignored);
                end
            end else begin
                want = pending_pins.pop_front();
                n_checked++;
                if (out_item.clk_out !== want.clk_out || out_item.dio_out !== want.dio_out ||
                    out_item.busy_res !== want.busy_res ||
                    out_item.req_ignored !== want.req_ignored) begin
                    n_bad++;
                    if (n_bad + n_stray <= 10) begin
                        $display("pin result %0d: expected clk %b dio %b busy %b dropped %b, got clk %b dio %b busy %b dropped %b",
                                 n_checked, want.clk_out, want.dio_out, want.busy_res,
                                 want.req_ignored, out_item.clk_out, out_item.dio_out,
                                 out_item.busy_res, out_item.req_ignored);
                    end
                end
            end
        end
    end

    initial begin
        int unsigned p;
        int unsigned k;
        logic [15:0] setting;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // The first rows run at the reset delay unit; the second pair shows a
        // request dropped while a frame is still going out.
        add_row(0, 0,     REQ_NONE,    0,     0, 32'h00000000, 0,  1, 4'b1100, 0);
        add_row(0, 0,     REQ_NONE,    16383, 7, 32'hffffffff, 15, 1, 4'b1100, 0);
        add_row(0, 0,     REQ_BRIGHT,  0,     0, 32'h00000000, 8,  1, 4'b1110, 0);
        add_row(0, 0,     REQ_DECIMAL, 1234,  0, 32'h00000000, 0,  1, 4'b1111, 1);
        add_row(1, 0,     REQ_DECIMAL, 0,     0, 32'h00000000, 0,  1, 4'b1110, 1);
        add_row(0, 0,     REQ_DECIMAL, 9999,  3, 32'h00000000, 0,  1, 4'b1110, 1);
        add_row(0, 0,     REQ_DECIMAL, 16383, 7, 32'h00000000, 0,  1, 4'b1110, 1);
        add_row(0, 0,     REQ_DECIMAL, 1234,  1, 32'h00000000, 0,  1, 4'b1110, 1);
        add_row(0, 0,     REQ_DECIMAL, 5678,  2, 32'h00000000, 0,  1, 4'b1110, 1);
        add_row(0, 0,     REQ_DECIMAL, 10,    4, 32'h00000000, 0,  1, 4'b1110, 1);
        add_row(0, 0,     REQ_RAW,     0,     0, 32'h00000000, 0,  1, 4'b1110, 1);
        add_row(0, 0,     REQ_RAW,     0,     0, 32'hffffffff, 0,  1, 4'b1110, 1);
        add_row(0, 0,     REQ_RAW,     0,     0, 32'ha55a0180, 0,  1, 4'b1110, 1);
        add_row(0, 0,     REQ_BRIGHT,  0,     0, 32'h00000000, 0,  1, 4'b1110, 1);
        add_row(0, 0,     REQ_BRIGHT,  0,     0, 32'h00000000, 15, 1, 4'b1110, 1);
        add_row(1, 1,     REQ_BRIGHT,  0,     0, 32'h00000000, 4,  1, 4'b1110, 0);
        add_row(0, 0,     REQ_RAW,     0,     0, 32'h12345678, 0,  0, 4'b0000, 1);
        add_row(1, 65535, REQ_BRIGHT,  0,     0, 32'h00000000, 1,  1, 4'b1110, 0);
        add_row(1, 0,     REQ_NONE,    0,     0, 32'h00000000, 0,  1, 4'b1110, 1);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].set_cfg) begin
                write_delay_unit(directed_rows[r].cfg);
            end
            send_tick(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].pins);
            if (directed_rows[r].drain) begin
                drain_sequencer();
            end
        end

        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: setting = 16'd0;
                1: setting = 16'd1;
                2: setting = 16'd0;
                3: setting = 16'd2;
                default: setting = 16'($urandom_range(1, 3));
            endcase
            write_delay_unit(setting);
            for (k = 0; k < RANDOM_TICKS; k++) begin
                if (k % 35 == 0) begin
                    gaps_on = ($urandom_range(0, 3) != 0);
                    stalls_on = ($urandom_range(0, 3) != 0);
                end
                // The receiver holds off while ticks keep coming, so the block backs up.
                if (p == 2 && k == 0) begin
                    hold_request = 1'b1;
                    gaps_on = 1'b0;
                end
                send_tick(random_tick(1'b1), 1'b0, '0);
            end
            drain_sequencer();
        end

        in_valid <= 1'b0;
        while (pending_pins.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d ticks and checked %0d pin results over %0d delay unit settings.",
                 n_ticks, n_checked, n_cfg);
        $display("Started %0d transfers; %0d requests arrived while busy and were dropped.",
                 n_started, n_dropped);
        if (n_bad == 0 && n_stray == 0 && pending_pins.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
sv/sss_pkg.sv
sv/sss_bcd.sv
sv/sss_seq.sv
sv/seven_segment_two_wire_sender.sv
tb/tb_top.sv
